### hdl/alcc_pkg.sv
package alcc_pkg;

	localparam int MAX_AGENTS_DEF = 1024;
	localparam int ID_W = 10;
	localparam int POS_W = 32;
	localparam int TIME_W = 32;
	localparam int CNT_W = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] ACT_REPORT = 2'd0;
	localparam logic [1:0] ACT_TIME = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LSX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LSY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BXMIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BXMAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BYMIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BYMAX = 3'd7;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_MUL,
		ST_CMP,
		ST_WRITE,
		ST_SWEEP_RD,
		ST_SWEEP_WR,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic init;
		logic load;
		logic rd;
		logic diff;
		logic mul;
		logic cmp;
		logic wr;
		logic sweep_start;
		logic sweep_rd;
		logic sweep_wr;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_test;
		logic sweep_last;
		logic rewind;
		logic wipe;
		logic is_report;
	} stat_t;

endpackage

### hdl/alcc_ctrl.sv
module alcc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  alcc_pkg::stat_t  stat,
	output alcc_pkg::cmd_t   cmd,
	output logic             busy
);

	alcc_pkg::state_t state_q, state_d;

	// advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= alcc_pkg::ST_INIT;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			alcc_pkg::ST_INIT: state_d = stat.sweep_last ? alcc_pkg::ST_IDLE
				: alcc_pkg::ST_INIT;
			alcc_pkg::ST_IDLE: if (start) state_d = alcc_pkg::ST_READ;
			alcc_pkg::ST_READ: begin
				if (stat.is_report) state_d = alcc_pkg::ST_DIFF;
				else if (stat.rewind || stat.wipe) state_d = alcc_pkg::ST_SWEEP_RD;
				else state_d = alcc_pkg::ST_DONE;
			end
			alcc_pkg::ST_DIFF: state_d = stat.need_test ? alcc_pkg::ST_MUL
				: alcc_pkg::ST_WRITE;
			alcc_pkg::ST_MUL: state_d = alcc_pkg::ST_CMP;
			alcc_pkg::ST_CMP: state_d = alcc_pkg::ST_WRITE;
			alcc_pkg::ST_WRITE: state_d = alcc_pkg::ST_DONE;
			alcc_pkg::ST_SWEEP_RD: state_d = alcc_pkg::ST_SWEEP_WR;
			alcc_pkg::ST_SWEEP_WR: state_d = stat.sweep_last ? alcc_pkg::ST_DONE
				: alcc_pkg::ST_SWEEP_RD;
			alcc_pkg::ST_DONE: state_d = alcc_pkg::ST_IDLE;
			default: state_d = alcc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			alcc_pkg::ST_INIT: cmd.init = 1'b1;
			alcc_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			alcc_pkg::ST_READ: begin
				cmd.rd = 1'b1;
				cmd.sweep_start = (stat.rewind | stat.wipe) & ~stat.is_report;
			end
			alcc_pkg::ST_DIFF: cmd.diff = 1'b1;
			alcc_pkg::ST_MUL: cmd.mul = 1'b1;
			alcc_pkg::ST_CMP: cmd.cmp = 1'b1;
			alcc_pkg::ST_WRITE: cmd.wr = 1'b1;
			alcc_pkg::ST_SWEEP_RD: cmd.sweep_rd = 1'b1;
			alcc_pkg::ST_SWEEP_WR: cmd.sweep_wr = 1'b1;
			alcc_pkg::ST_DONE: cmd.emit = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

### hdl/alcc_datapath.sv
module alcc_datapath #(
	parameter int MAX_AGENTS = alcc_pkg::MAX_AGENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  alcc_pkg::cmd_t                    cmd,
	output alcc_pkg::stat_t                   stat,
	input  logic [1:0]                        action,
	input  logic [alcc_pkg::ID_W-1:0]         agent_id,
	input  logic signed [alcc_pkg::POS_W-1:0] pos_x,
	input  logic signed [alcc_pkg::POS_W-1:0] pos_y,
	input  logic [alcc_pkg::TIME_W-1:0]       sim_time,
	input  logic                              cfg_valid,
	input  logic [alcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [alcc_pkg::POS_W-1:0]        cfg_data,
	output logic                              done,
	output logic                              crossed,
	output logic                              ignored,
	output logic                              already_passed,
	output logic [alcc_pkg::CNT_W-1:0]        crossing_count
);

	localparam int AW = (MAX_AGENTS > 2) ? $clog2(MAX_AGENTS) : 1;
	localparam int SW = AW + 1;
	localparam int PW = alcc_pkg::POS_W;
	localparam int DW = PW + 1;
	localparam int MW = 2 * DW + 1;
	localparam int CNT_W = alcc_pkg::CNT_W;

	// configuration registers
	logic signed [PW-1:0] lsx_q, lsy_q, lex_q, ley_q;
	logic signed [PW-1:0] bxmin_q, bxmax_q, bymin_q, bymax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsx_q <= '0; lsy_q <= '0; lex_q <= '0; ley_q <= '0;
			bxmin_q <= '0; bxmax_q <= '0; bymin_q <= '0; bymax_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				alcc_pkg::REG_LSX: lsx_q <= cfg_data;
				alcc_pkg::REG_LSY: lsy_q <= cfg_data;
				alcc_pkg::REG_LEX: lex_q <= cfg_data;
				alcc_pkg::REG_LEY: ley_q <= cfg_data;
				alcc_pkg::REG_BXMIN: bxmin_q <= cfg_data;
				alcc_pkg::REG_BXMAX: bxmax_q <= cfg_data;
				alcc_pkg::REG_BYMIN: bymin_q <= cfg_data;
				alcc_pkg::REG_BYMAX: bymax_q <= cfg_data;
				default: lsx_q <= lsx_q;
			endcase
		end
	end

	// request registers
	logic [1:0]           act_q;
	logic [alcc_pkg::ID_W-1:0] id_q;
	logic signed [PW-1:0] cx_q, cy_q;
	logic [alcc_pkg::TIME_W-1:0] t_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action; id_q <= agent_id;
			cx_q <= pos_x; cy_q <= pos_y; t_q <= sim_time;
		end
	end

	logic id_ok;
	assign id_ok = (int'(id_q) < MAX_AGENTS);
	logic [AW-1:0] idx;
	assign idx = AW'(id_q);

	// tracked and counted flags, positions and stamps all kept in memories
	logic [1:0] flag_mem [MAX_AGENTS];
	logic [2*PW-1:0] pos_mem [MAX_AGENTS];
	logic [alcc_pkg::TIME_W-1:0] time_mem [MAX_AGENTS];
	logic [1:0] flag_rd_q;
	logic [2*PW-1:0] pos_rd_q;
	logic [alcc_pkg::TIME_W-1:0] time_rd_q;
	logic [alcc_pkg::TIME_W-1:0] cur_time_q;
	logic [alcc_pkg::CNT_W-1:0] cnt_q;
	logic [SW-1:0] sw_q;

	logic [AW-1:0] rd_addr;
	assign rd_addr = cmd.sweep_rd ? sw_q[AW-1:0] : idx;

	always_ff @(posedge clk) begin
		flag_rd_q <= flag_mem[rd_addr];
		pos_rd_q <= pos_mem[rd_addr];
		time_rd_q <= time_mem[rd_addr];
	end

	logic trk_rd, pas_rd;
	assign trk_rd = flag_rd_q[1];
	assign pas_rd = flag_rd_q[0];

	logic in_box;
	assign in_box = (cx_q >= bxmin_q) && (cx_q <= bxmax_q) &&
		(cy_q >= bymin_q) && (cy_q <= bymax_q);

	logic is_rep;
	assign is_rep = (act_q == alcc_pkg::ACT_REPORT);
	logic is_wipe;
	assign is_wipe = (act_q == alcc_pkg::ACT_CLEAR);
	logic rep_live;
	assign rep_live = is_rep && id_ok && !pas_rd;
	logic tested;
	assign tested = rep_live && trk_rd;

	assign stat.is_report = is_rep;
	assign stat.rewind = (act_q == alcc_pkg::ACT_TIME) && !(cur_time_q < t_q);
	assign stat.wipe = is_wipe;
	assign stat.need_test = tested;
	assign stat.sweep_last = (sw_q == SW'(MAX_AGENTS - 1));

	// differences
	logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q;
	logic signed [PW-1:0] px, py;
	assign px = pos_rd_q[2*PW-1:PW];
	assign py = pos_rd_q[PW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			d1x_q <= DW'(cx_q) - DW'(px);
			d1y_q <= DW'(cy_q) - DW'(py);
			d2x_q <= DW'(lex_q) - DW'(lsx_q);
			d2y_q <= DW'(ley_q) - DW'(lsy_q);
			ex_q <= DW'(px) - DW'(lsx_q);
			ey_q <= DW'(py) - DW'(lsy_q);
		end
	end

	// products, one register after each difference of two products
	logic signed [MW-1:0] det_s1, n1_s1, n2_s1;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			det_s1 <= MW'(d1x_q) * MW'(d2y_q) - MW'(d1y_q) * MW'(d2x_q);
			n1_s1 <= MW'(d2x_q) * MW'(ey_q) - MW'(d2y_q) * MW'(ex_q);
			n2_s1 <= MW'(d1x_q) * MW'(ey_q) - MW'(d1y_q) * MW'(ex_q);
		end
	end

	// compare against the determinant
	logic hit_q;
	logic signed [MW-1:0] dn, a1, a2;
	always_comb begin
		dn = det_s1[MW-1] ? -det_s1 : det_s1;
		a1 = det_s1[MW-1] ? -n1_s1 : n1_s1;
		a2 = det_s1[MW-1] ? -n2_s1 : n2_s1;
	end
	always_ff @(posedge clk) begin
		if (cmd.diff) hit_q <= 1'b0;
		else if (cmd.cmp)
			hit_q <= (det_s1 != '0) && (a1 >= 0) && (a1 <= dn) && (a2 >= 0) && (a2 <= dn);
	end

	// write back, sweep and result
	logic cr_q, ig_q, ap_q;
	logic [alcc_pkg::CNT_W-1:0] swcnt_q;
	logic keep_pas;
	assign keep_pas = pas_rd && !is_wipe && !(time_rd_q > cur_time_q);

	always_ff @(posedge clk) begin
		if (cmd.wr && rep_live) begin
			if (tested && hit_q) time_mem[idx] <= cur_time_q;
			else if (in_box) pos_mem[idx] <= {cx_q, cy_q};
		end
	end

	// clear flags after reset, drop tracked and stale or cleared counted flags on a sweep, update them on a report
	always_ff @(posedge clk) begin
		if (cmd.init) flag_mem[sw_q[AW-1:0]] <= 2'b00;
		else if (cmd.sweep_wr) flag_mem[sw_q[AW-1:0]] <= {1'b0, keep_pas};
		else if (cmd.wr && rep_live) flag_mem[idx] <= {in_box, tested && hit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; cur_time_q <= '0;
			sw_q <= '0; swcnt_q <= '0;
			cr_q <= 1'b0; ig_q <= 1'b0; ap_q <= 1'b0; done <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cmd.load) begin
				cr_q <= 1'b0; ig_q <= 1'b0; ap_q <= 1'b0;
			end
			if (cmd.rd && act_q == alcc_pkg::ACT_TIME) cur_time_q <= t_q;
			if (cmd.diff) begin
				if (!id_ok) ig_q <= 1'b1;
				else if (pas_rd) begin ig_q <= 1'b1; ap_q <= 1'b1; end
				else if (!trk_rd && !in_box) ig_q <= 1'b1;
			end
			if (cmd.sweep_start) begin
				sw_q <= '0; swcnt_q <= '0;
			end
			if (cmd.init) sw_q <= sw_q + 1'b1;
			if (cmd.wr && tested && hit_q) begin
				cnt_q <= cnt_q + 1'b1;
				cr_q <= 1'b1;
			end
			if (cmd.sweep_wr) begin
				swcnt_q <= swcnt_q + CNT_W'(keep_pas);
				if (stat.sweep_last)
					cnt_q <= swcnt_q + CNT_W'(keep_pas);
				sw_q <= sw_q + 1'b1;
			end
		end
	end

	assign crossed = cr_q;
	assign ignored = ig_q;
	assign already_passed = ap_q;
	assign crossing_count = cnt_q;

endmodule

### hdl/agent_line_crossing_counter.sv
// Agent line crossing counter.
// Requests enter on start/busy: one is taken at a clock edge where start is
// high and busy low. Actions: position report, time update, clear all.
// Each request yields exactly one result, shown for one cycle with done high:
// crossed, ignored, already_passed and crossing_count. The receiver cannot
// stall; a result must be taken in the cycle it appears.
// Position reports that need a crossing test pass through the read,
// difference, multiply, compare, write and done states; other reports skip
// multiply and compare; forward time updates and unused actions go from read
// straight to done. A rewind (a time update that does not move forward) and a
// clear walk all MAX_AGENTS table entries, a sweep read and a sweep write state
// per entry; the single read port of the flag and time tables sets this. Busy
// falls in the cycle the result is shown, so one request is in flight.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high and writes are meant
// only while the block is idle.
// Reset clears the line and box registers, the count and the current time;
// a clearing pass over all MAX_AGENTS entries then zeroes the flag table, with
// busy held high until it ends.
module agent_line_crossing_counter #(
	parameter int MAX_AGENTS = alcc_pkg::MAX_AGENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic [alcc_pkg::ID_W-1:0]         agent_id,
	input  logic signed [alcc_pkg::POS_W-1:0] pos_x,
	input  logic signed [alcc_pkg::POS_W-1:0] pos_y,
	input  logic [alcc_pkg::TIME_W-1:0]       sim_time,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [alcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [alcc_pkg::POS_W-1:0]        cfg_data,
	output logic                              done,
	output logic                              crossed,
	output logic                              ignored,
	output logic                              already_passed,
	output logic [alcc_pkg::CNT_W-1:0]        crossing_count
);

	alcc_pkg::cmd_t cmd;
	alcc_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	alcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
	);

	alcc_datapath #(.MAX_AGENTS(MAX_AGENTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .agent_id(agent_id), .pos_x(pos_x), .pos_y(pos_y),
		.sim_time(sim_time), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .crossed(crossed), .ignored(ignored),
		.already_passed(already_passed), .crossing_count(crossing_count)
	);

`ifndef NO_ASSERTIONS
	// a result only comes while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without request");
	// a new crossing is never also ignored
	a_cross_ign: assert property (@(posedge clk) disable iff (!arst_n)
		done && crossed |-> !ignored && !already_passed) else $error("flag clash");
	// a counted crossing leaves a nonzero count
	a_cross_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done && crossed |-> crossing_count != '0) else $error("count not bumped");
	// accepting a request raises busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
`endif

endmodule

### sim/tb_top.sv
module tb_top;
	import alcc_pkg::*;

	typedef struct {
		logic [1:0]         act;
		logic [ID_W-1:0]    id;
		logic [POS_W-1:0]   px;
		logic [POS_W-1:0]   py;
		logic [TIME_W-1:0]  t;
	} req_t;

	typedef struct {
		logic             crossed;
		logic             ignored;
		logic             already;
		logic [CNT_W-1:0] count;
	} tally_t;

	localparam int NUM_AGENTS = 1024;
	localparam int CYCLE_LIMIT = 10000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] action = ACT_REPORT;
	logic [ID_W-1:0] agent_id = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic [TIME_W-1:0] sim_time = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_data = '0;
	logic busy, cfg_ready, done, crossed, ignored, already_passed;
	logic [CNT_W-1:0] crossing_count;

	agent_line_crossing_counter u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .agent_id(agent_id), .pos_x(pos_x), .pos_y(pos_y),
		.sim_time(sim_time), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.crossed(crossed), .ignored(ignored), .already_passed(already_passed),
		.crossing_count(crossing_count)
	);

	always #6 clk = ~clk;

	// tripwire state mirror
	longint line_sx, line_sy, line_ex, line_ey;
	longint bx_min, bx_max, by_min, by_max;
	bit tracked [NUM_AGENTS];
	longint last_x [NUM_AGENTS];
	longint last_y [NUM_AGENTS];
	bit counted [NUM_AGENTS];
	logic [TIME_W-1:0] stamp [NUM_AGENTS];
	int unsigned total_counted;
	logic [TIME_W-1:0] now_time;

	req_t pending_reqs[$];
	tally_t expected_tallies[$];
	int errors = 0;
	int accepted = 0;
	int crossings_seen = 0;
	int rewinds_seen = 0;
	int cycles = 0;

	function automatic logic signed [127:0] cross2(longint ux, longint uy, longint vx,
			longint vy);
		logic signed [127:0] a, b, c, d;
		a = ux;
		b = uy;
		c = vx;
		d = vy;
		return a * d - b * c;
	endfunction

	function automatic bit segment_hits_line(longint px, longint py, longint cx, longint cy);
		logic signed [127:0] det, n1, n2;
		longint d1x, d1y, d2x, d2y, ex, ey;
		d1x = cx - px;
		d1y = cy - py;
		d2x = line_ex - line_sx;
		d2y = line_ey - line_sy;
		ex = px - line_sx;
		ey = py - line_sy;
		det = cross2(d1x, d1y, d2x, d2y);
		if (det == 0)
			return 1'b0;
		n1 = cross2(d2x, d2y, ex, ey);
		n2 = cross2(d1x, d1y, ex, ey);
		if (det < 0) begin
			det = -det;
			n1 = -n1;
			n2 = -n2;
		end
		return n1 >= 0 && n1 <= det && n2 >= 0 && n2 <= det;
	endfunction

	function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] v);
		longint s;
		s = longint'(signed'(v));
		case (idx)
			REG_LSX: line_sx = s;
			REG_LSY: line_sy = s;
			REG_LEX: line_ex = s;
			REG_LEY: line_ey = s;
			REG_BXMIN: bx_min = s;
			REG_BXMAX: bx_max = s;
			REG_BYMIN: by_min = s;
			default: by_max = s;
		endcase
	endfunction

	// advance the mirror by one request and return its tally
	function automatic tally_t apply_request(req_t r);
		tally_t o;
		longint cx, cy;
		bit in_box;
		o = '{1'b0, 1'b0, 1'b0, '0};
		case (r.act)
			ACT_REPORT: begin
				if (counted[r.id]) begin
					o.ignored = 1'b1;
					o.already = 1'b1;
				end else begin
					cx = longint'(signed'(r.px));
					cy = longint'(signed'(r.py));
					in_box = cx >= bx_min && cx <= bx_max && cy >= by_min && cy <= by_max;
					if (tracked[r.id]) begin
						if (segment_hits_line(last_x[r.id], last_y[r.id], cx, cy)) begin
							counted[r.id] = 1'b1;
							stamp[r.id] = now_time;
							total_counted++;
							o.crossed = 1'b1;
						end else if (in_box) begin
							last_x[r.id] = cx;
							last_y[r.id] = cy;
						end
						if (!in_box)
							tracked[r.id] = 1'b0;
					end else if (in_box) begin
						tracked[r.id] = 1'b1;
						last_x[r.id] = cx;
						last_y[r.id] = cy;
					end else begin
						o.ignored = 1'b1;
					end
				end
			end
			ACT_TIME: begin
				if (now_time >= r.t) begin
					total_counted = 0;
					for (int i = 0; i < NUM_AGENTS; i++) begin
						if (counted[i] && stamp[i] > r.t)
							counted[i] = 1'b0;
						if (counted[i])
							total_counted++;
						tracked[i] = 1'b0;
					end
				end
				now_time = r.t;
			end
			ACT_CLEAR: begin
				for (int i = 0; i < NUM_AGENTS; i++) begin
					tracked[i] = 1'b0;
					counted[i] = 1'b0;
				end
				total_counted = 0;
			end
			default: ;
		endcase
		o.count = total_counted[CNT_W-1:0];
		return o;
	endfunction

	// driver: issue requests in bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		req_t r;
		tally_t e;
		bit took;
		cycles++;
		took = start && !busy;
		if (took) begin
			r = '{action, agent_id, pos_x, pos_y, sim_time};
			if (action == ACT_TIME && sim_time <= now_time)
				rewinds_seen++;
			e = apply_request(r);
			expected_tallies.push_back(e);
			accepted++;
		end
		if (!(start && !took)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				action <= r.act;
				agent_id <= r.id;
				pos_x <= r.px;
				pos_y <= r.py;
				sim_time <= r.t;
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				start <= 1'b0;
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		tally_t e;
		if (arst_n && done) begin
			if (expected_tallies.size() == 0) begin
				$display("%0t: unexpected result crossed=%0b ignored=%0b count=%0d", $time,
					crossed, ignored, crossing_count);
				errors++;
			end else begin
				e = expected_tallies.pop_front();
				if (crossed !== e.crossed) begin
					$display("%0t: crossed expected %0b actual %0b", $time, e.crossed, crossed);
					errors++;
				end
				if (ignored !== e.ignored) begin
					$display("%0t: ignored expected %0b actual %0b", $time, e.ignored, ignored);
					errors++;
				end
				if (already_passed !== e.already) begin
					$display("%0t: already_passed expected %0b actual %0b", $time, e.already,
						already_passed);
					errors++;
				end
				if (crossing_count !== e.count) begin
					$display("%0t: crossing_count expected %0d actual %0d", $time, e.count,
						crossing_count);
					errors++;
				end
				if (crossed === 1'b1)
					crossings_seen++;
			end
		end
	end

	// stimulus generation state
	longint gen_lo_x, gen_hi_x, gen_lo_y, gen_hi_y;
	logic [TIME_W-1:0] gen_time = '0;
	logic [ID_W-1:0] id_pool [12];

	function automatic longint pick_between(longint lo, longint hi);
		longint unsigned span, r;
		span = longint'(hi - lo) + 1;
		r = {$urandom, $urandom};
		return lo + longint'(r % span);
	endfunction

	function automatic longint clip32(longint v);
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		return v;
	endfunction

	function automatic req_t report(logic [ID_W-1:0] id, longint x, longint y);
		return '{ACT_REPORT, id, POS_W'(x), POS_W'(y), TIME_W'($urandom)};
	endfunction

	function automatic req_t time_update(logic [TIME_W-1:0] t);
		return '{ACT_TIME, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom), t};
	endfunction

	function automatic req_t random_request();
		req_t r;
		int sel;
		logic [ID_W-1:0] id;
		sel = $urandom_range(0, 99);
		id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 11)] : ID_W'($urandom);
		if (sel < 80) begin
			if ($urandom_range(0, 9) == 0)
				r = report(id, longint'(signed'($urandom)), longint'(signed'($urandom)));
			else
				r = report(id, pick_between(gen_lo_x, gen_hi_x), pick_between(gen_lo_y,
					gen_hi_y));
		end else if (sel < 95) begin
			// forward mostly, now and then an arbitrary time that may rewind
			if ($urandom_range(0, 24) == 0 || gen_time > 32'hFFF0_0000)
				gen_time = $urandom;
			else
				gen_time = gen_time + $urandom_range(1, 5000);
			r = time_update(gen_time);
		end else if (sel < 98) begin
			r = time_update(gen_time);
			r.act = ACT_CLEAR;
		end else begin
			r = time_update(gen_time);
			r.act = ACT_SPARE;
		end
		return r;
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || expected_tallies.size() > 0 || start)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic load_setup(longint lsx, longint lsy, longint lex, longint ley,
			longint xmin, longint xmax, longint ymin, longint ymax);
		logic [POS_W-1:0] vals [8];
		longint mx, my;
		vals = '{POS_W'(lsx), POS_W'(lsy), POS_W'(lex), POS_W'(ley), POS_W'(xmin),
			POS_W'(xmax), POS_W'(ymin), POS_W'(ymax)};
		wait_idle();
		for (int i = 0; i < 8; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			set_register(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		if (xmin > xmax || ymin > ymax) begin
			gen_lo_x = -300; gen_hi_x = 300; gen_lo_y = -300; gen_hi_y = 300;
		end else begin
			mx = (xmax - xmin) / 8;
			my = (ymax - ymin) / 8;
			gen_lo_x = clip32(xmin - mx); gen_hi_x = clip32(xmax + mx);
			gen_lo_y = clip32(ymin - my); gen_hi_y = clip32(ymax + my);
		end
		for (int i = 0; i < 12; i++)
			id_pool[i] = ID_W'($urandom);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(random_request());
	endtask

	initial begin
		line_sx = 0; line_sy = 0; line_ex = 0; line_ey = 0;
		bx_min = 0; bx_max = 0; by_min = 0; by_max = 0;
		total_counted = 0;
		now_time = '0;
		for (int i = 0; i < NUM_AGENTS; i++) begin
			tracked[i] = 1'b0;
			counted[i] = 1'b0;
		end
		gen_lo_x = -4; gen_hi_x = 4; gen_lo_y = -4; gen_hi_y = 4;
		for (int i = 0; i < 12; i++)
			id_pool[i] = ID_W'(i);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset setup: point box, zero length line
		queue_random(40);

		// directed checks on a line across a mid-size box
		load_setup(-8000, -5000, 7000, 6000, -10000, 10000, -10000, 10000);
		pending_reqs.push_back(report(5, -5000, 3000));
		pending_reqs.push_back(report(5, 5000, -3000));
		pending_reqs.push_back(report(5, 0, 0));
		pending_reqs.push_back(report(6, 20000, 0));
		pending_reqs.push_back(report(7, -6000, 4000));
		pending_reqs.push_back(report(7, 9000, -20000));
		pending_reqs.push_back(report(7, 9000, -9000));
		pending_reqs.push_back(report(8, -8000, 0));
		pending_reqs.push_back(report(8, -8000, -5000));
		pending_reqs.push_back(report(9, -10000, -10000));
		pending_reqs.push_back(report(9, 10000, 10000));
		pending_reqs.push_back(report(0, -64'sd2147483648, 64'sd2147483647));
		pending_reqs.push_back(report(1023, 64'sd2147483647, -64'sd2147483648));
		pending_reqs.push_back(time_update(32'hFFFF_FFFF));
		pending_reqs.push_back(report(10, 100, -100));
		pending_reqs.push_back(report(10, -100, 100));
		pending_reqs.push_back(time_update(32'hFFFF_FFFF));
		pending_reqs.push_back(time_update(32'h0000_0000));
		pending_reqs.push_back(report(5, 100, 100));
		pending_reqs.push_back(report(11, -5000, 3000));
		pending_reqs.push_back(report(11, 5000, -3000));
		pending_reqs.push_back('{ACT_CLEAR, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0});
		pending_reqs.push_back('{ACT_SPARE, 10'h2AA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234});
		pending_reqs.push_back(report(11, 0, 0));
		gen_time = '0;
		queue_random(320);

		// full range box, diagonal line between opposite corners
		load_setup(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
			-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
		queue_random(320);

		// empty box: nothing is ever tracked
		load_setup(64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
			100, -100, 100, -100);
		queue_random(150);

		// small box with a vertical line through it
		load_setup(0, -40, 0, 40, -50, 50, -50, 50);
		queue_random(450);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("requests %0d, crossings %0d, rewinds %0d over five line and box setups",
			accepted, crossings_seen, rewinds_seen);
		if (expected_tallies.size() > 0) begin
			$display("%0d results never arrived", expected_tallies.size());
			errors++;
		end
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
